>>> hdl/rbd_pkg.sv
`default_nettype none

package rbd_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int STORE_DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int SIZE_W       = 13;
  localparam int CNT_W        = 12;
  localparam int CHAN_W       = 8;
  localparam int PAIR_W       = CHAN_W + 1;
  localparam int LANES        = 4;
  localparam int WORD_W       = LANES * PAIR_W;

  localparam int SIZE_MIN     = 2;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(SIZE_MIN)) begin
      r = SIZE_W'(SIZE_MIN);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rbd_line_store.sv
`default_nettype none

module rbd_line_store (
  input  wire logic                       clk_i,
  input  wire rbd_pkg::store_req_t        req_i,
  output logic [rbd_pkg::WORD_W-1:0]      rdata_o
);

  logic [rbd_pkg::WORD_W-1:0] mem [rbd_pkg::STORE_DEPTH];
  logic [rbd_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/rbd_lane.sv
`default_nettype none

module rbd_lane (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic [rbd_pkg::CHAN_W-1:0]  left_i,
  input  wire logic [rbd_pkg::CHAN_W-1:0]  pix_i,
  input  wire logic [rbd_pkg::PAIR_W-1:0]  above_i,
  output logic      [rbd_pkg::PAIR_W-1:0]  pair_o,
  output logic      [rbd_pkg::CHAN_W-1:0]  avg_o
);

  logic [rbd_pkg::PAIR_W-1:0] pair_q;
  logic [rbd_pkg::PAIR_W:0]   sum;

  assign pair_o = {1'b0, left_i} + {1'b0, pix_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_o;
    end
  end

  // four-pixel sum, truncated average
  assign sum   = {1'b0, pair_q} + {1'b0, above_i};
  assign avg_o = sum[rbd_pkg::PAIR_W:2];

endmodule

`default_nettype wire

>>> hdl/rgba_box_downscale_2x2.sv
// an accepted beat's result passes the merge stage, then the output register
// throughput: one pixel per cycle unless output stalls, one result per 2x2 block
// the line store is read on the accept edge and its registered data meets the
//   held pair sums in the merge stage, the output register parts the sides
// reset: asynchronous active low, clears counters, held pixel, valids and sizes
//   (640 x 480); line store contents stay undefined until written
`default_nettype none

module rgba_box_downscale_2x2 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rbd_pkg::CHAN_W-1:0]    red_in_i,
  input  wire logic [rbd_pkg::CHAN_W-1:0]    green_in_i,
  input  wire logic [rbd_pkg::CHAN_W-1:0]    blue_in_i,
  input  wire logic [rbd_pkg::CHAN_W-1:0]    alpha_in_i,
  input  wire logic                          frame_start_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rbd_pkg::CHAN_W-1:0]    red_out_o,
  output logic      [rbd_pkg::CHAN_W-1:0]    green_out_o,
  output logic      [rbd_pkg::CHAN_W-1:0]    blue_out_o,
  output logic      [rbd_pkg::CHAN_W-1:0]    alpha_out_o,
  output logic                               row_end_o,
  output logic                               frame_end_o,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [rbd_pkg::SIZE_W-1:0]    cfg_data_i
);

  localparam int LW = rbd_pkg::LANES * rbd_pkg::CHAN_W;

  logic [rbd_pkg::SIZE_W-1:0] width_q, height_q;
  logic [rbd_pkg::SIZE_W-1:0] w, h;
  logic [rbd_pkg::CNT_W-1:0]  ow, oh;
  logic [rbd_pkg::CNT_W-1:0]  col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [rbd_pkg::CNT_W-1:0]  c, r;
  logic [rbd_pkg::SIZE_W-1:0] c_inc, r_inc;
  logic [rbd_pkg::ADDR_W-1:0] col;
  logic [LW-1:0]              left_q, pix;
  logic                       in_acc, pair_ok, wr_row, emit, rend, fend;
  logic                       s1_valid_q, s1_rend_q, s1_fend_q, s1_adv;
  logic                       out_valid_q, row_end_q, frame_end_q;
  logic [LW-1:0]              out_pix_q, avg;
  logic [rbd_pkg::WORD_W-1:0] pairs, above;
  rbd_pkg::store_req_t        req;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbd_pkg::SIZE_W'(rbd_pkg::RESET_WIDTH);
      height_q <= rbd_pkg::SIZE_W'(rbd_pkg::RESET_HEIGHT);
    end else if (cfg_valid_i) begin
      case (rbd_pkg::reg_idx_e'(cfg_index_i))
        rbd_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rbd_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w  = rbd_pkg::clamp_size(width_q, rbd_pkg::SIZE_W'(rbd_pkg::MAX_WIDTH));
  assign h  = rbd_pkg::clamp_size(height_q, rbd_pkg::SIZE_W'(rbd_pkg::HEIGHT_LIMIT));
  assign ow = w[rbd_pkg::SIZE_W-1:1];
  assign oh = h[rbd_pkg::SIZE_W-1:1];

  // position of the incoming pixel
  assign in_acc = in_valid_i && in_ready_o;
  assign c      = frame_start_i ? '0 : col_cnt_q;
  assign r      = frame_start_i ? '0 : row_cnt_q;
  assign c_inc  = {1'b0, c} + rbd_pkg::SIZE_W'(1);
  assign r_inc  = {1'b0, r} + rbd_pkg::SIZE_W'(1);
  assign col    = c[rbd_pkg::CNT_W-1:1];

  assign pair_ok = c[0] && ({1'b0, col} < ow) && ({1'b0, r} < h);
  assign wr_row  = pair_ok && !r[0];
  assign emit    = pair_ok && r[0] && ({1'b0, r[rbd_pkg::CNT_W-1:1]} < oh);
  assign rend    = ({1'b0, col} == ow - rbd_pkg::CNT_W'(1));
  assign fend    = rend && ({1'b0, r[rbd_pkg::CNT_W-1:1]} == oh - rbd_pkg::CNT_W'(1));

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (in_acc) begin
      if (c_inc >= w) begin
        col_cnt_d = '0;
        row_cnt_d = (r_inc >= h) ? '0 : r_inc[rbd_pkg::CNT_W-1:0];
      end else begin
        col_cnt_d = c_inc[rbd_pkg::CNT_W-1:0];
        row_cnt_d = r;
      end
    end
  end

  assign pix = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      left_q    <= '0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      if (in_acc && !c[0]) begin
        left_q <= pix;
      end
    end
  end

  // channel lanes
  for (genvar k = 0; k < rbd_pkg::LANES; k++) begin : g_lane
    rbd_lane u_lane (
      .clk_i   (clk_i),
      .load_i  (in_acc && emit),
      .left_i  (left_q[k*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]),
      .pix_i   (pix[k*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W]),
      .above_i (above[k*rbd_pkg::PAIR_W +: rbd_pkg::PAIR_W]),
      .pair_o  (pairs[k*rbd_pkg::PAIR_W +: rbd_pkg::PAIR_W]),
      .avg_o   (avg[k*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W])
    );
  end

  // line store of pair sums from even rows
  always_comb begin
    req.wr_en   = in_acc && wr_row;
    req.wr_addr = col;
    req.wr_data = pairs;
    req.rd_en   = in_acc && emit;
    req.rd_addr = col;
  end

  rbd_line_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (above)
  );

  // merge stage and output register
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= emit;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      s1_rend_q <= rend;
      s1_fend_q <= fend;
    end
    if (s1_adv) begin
      out_pix_q   <= avg;
      row_end_q   <= s1_rend_q;
      frame_end_q <= s1_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q[0*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W];
  assign green_out_o = out_pix_q[1*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W];
  assign blue_out_o  = out_pix_q[2*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W];
  assign alpha_out_o = out_pix_q[3*rbd_pkg::CHAN_W +: rbd_pkg::CHAN_W];
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

  a_fend_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!frame_end_o || row_end_o))
    else $error("frame end without row end");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free pipeline");

  a_emit_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> s1_valid_q)
    else $error("result lost after accept");

  a_no_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.wr_en && req.rd_en))
    else $error("store read and write in one beat");

endmodule

`default_nettype wire
